### src/bqd_pkg.sv
// Shared types, constants and the control store of the biquad filter.
// Used by bqd_sequencer, bqd_datapath and biquad_iir_filter.
package bqd_pkg;

    // Default widths, fixed register widths and register map
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int COEF_W             = 20;
    localparam int GAIN_W             = 24;
    localparam int CFG_DATA_W         = 24;
    localparam int CFG_IDX_W          = 3;
    localparam int STEP_W             = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FEED_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd5;

    typedef logic [STEP_W-1:0] t_step;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        DSEL_SAMP,
        DSEL_X,
        DSEL_X1,
        DSEL_X2,
        DSEL_Y1,
        DSEL_Y2
    } t_dsel;

    typedef enum logic [2:0] {
        CSEL_GAIN,
        CSEL_B0,
        CSEL_B1,
        CSEL_B2,
        CSEL_A1,
        CSEL_A2
    } t_csel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_accop;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_INPUT,
        JC_OUT_BUSY
    } t_jcond;

    // One microcode word
    typedef struct packed {
        logic   in_ready;
        t_dsel  dsel;
        t_csel  csel;
        t_accop acc_op;
        logic   store_x;
        logic   finish;
        t_jcond jcond;
        t_step  target;
        logic   last;
    } t_uword;

    // Strobes from sequencer to datapath
    typedef struct packed {
        t_dsel  dsel;
        t_csel  csel;
        t_accop acc_op;
        logic   store_x;
        logic   latch_in;
        logic   commit;
    } t_dp_ctl;

    // Coefficient set as loaded by software
    typedef struct packed {
        logic signed [COEF_W-1:0] feed_b0;
        logic signed [COEF_W-1:0] feed_b1;
        logic signed [COEF_W-1:0] feed_b2;
        logic signed [COEF_W-1:0] back_a1;
        logic signed [COEF_W-1:0] back_a2;
        logic signed [GAIN_W-1:0] input_gain;
    } t_coefs;

    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_FINISH = 4'd8;

    // Control store. The multiplier result of one step is consumed by the
    // accumulator (or the x register) in the following step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{in_ready: 1'b0, dsel: DSEL_SAMP, csel: CSEL_GAIN, acc_op: ACC_HOLD,
              store_x: 1'b0, finish: 1'b0, jcond: JC_NONE, target: STEP_IDLE,
              last: 1'b0};
        unique case (step)
            4'd0: begin
                w.in_ready = 1'b1;
                w.jcond    = JC_NO_INPUT;
                w.target   = STEP_IDLE;
            end
            4'd1: begin
                w.dsel = DSEL_SAMP;
                w.csel = CSEL_GAIN;
            end
            4'd2: begin
                w.dsel    = DSEL_X1;
                w.csel    = CSEL_B1;
                w.store_x = 1'b1;
            end
            4'd3: begin
                w.dsel   = DSEL_X;
                w.csel   = CSEL_B0;
                w.acc_op = ACC_LOAD;
            end
            4'd4: begin
                w.dsel   = DSEL_X2;
                w.csel   = CSEL_B2;
                w.acc_op = ACC_ADD;
            end
            4'd5: begin
                w.dsel   = DSEL_Y1;
                w.csel   = CSEL_A1;
                w.acc_op = ACC_ADD;
            end
            4'd6: begin
                w.dsel   = DSEL_Y2;
                w.csel   = CSEL_A2;
                w.acc_op = ACC_SUB;
            end
            4'd7: begin
                w.acc_op = ACC_SUB;
            end
            4'd8: begin
                w.finish = 1'b1;
                w.jcond  = JC_OUT_BUSY;
                w.target = STEP_FINISH;
                w.last   = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### src/biquad_iir_filter.sv
// Top level of the direct form I biquad: coefficient registers, output
// register, sequencer and datapath. Depends on bqd_pkg, bqd_sequencer, bqd_datapath.
//
//   port group        direction  handshake             payload
//   input samples     in         i_in_valid/o_in_ready  i_sample_in
//   filtered samples  out        o_out_valid/i_out_ready o_sample_out
//   coefficients      in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// When the output register is free, a sample runs through the accept step
// plus eight sequenced steps, as one shared multiplier does six products in turn.
// The result enters the output register at the final step.
// Reset (synchronous, active low) restores unity gain and b0, clears the rest.
// A full output register holds the final step; the next sample is accepted
// while a finished result still waits in the output register.
module biquad_iir_filter #(
    parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]    o_sample_out,
    input  logic                             i_cfg_we,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bqd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bqd_pkg::*;

    t_coefs                        r_coefs;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    t_dp_ctl                       ctl;
    logic                          out_busy;
    logic signed [SAMPLE_BITS-1:0] y;

    // Coefficient registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.feed_b0    <= COEF_W'(1) << COEF_FRAC_BITS;
            r_coefs.feed_b1    <= '0;
            r_coefs.feed_b2    <= '0;
            r_coefs.back_a1    <= '0;
            r_coefs.back_a2    <= '0;
            r_coefs.input_gain <= GAIN_W'(1) << COEF_FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FEED_B0:    r_coefs.feed_b0    <= i_cfg_data[COEF_W-1:0];
                REG_FEED_B1:    r_coefs.feed_b1    <= i_cfg_data[COEF_W-1:0];
                REG_FEED_B2:    r_coefs.feed_b2    <= i_cfg_data[COEF_W-1:0];
                REG_BACK_A1:    r_coefs.back_a1    <= i_cfg_data[COEF_W-1:0];
                REG_BACK_A2:    r_coefs.back_a2    <= i_cfg_data[COEF_W-1:0];
                REG_INPUT_GAIN: r_coefs.input_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_busy = r_out_valid && !i_out_ready;

    bqd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl)
    );

    bqd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_coefs  (r_coefs),
        .i_sample (i_sample_in),
        .o_y      (y)
    );

    // Output register: load on commit, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.commit) begin
            r_sample_out <= y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

### src/bqd_sequencer.sv
// Step counter and control store lookup with conditional jumps.
// Depends on bqd_pkg.
module bqd_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_busy,
    output logic             o_in_ready,
    output bqd_pkg::t_dp_ctl o_ctl
);
    import bqd_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w;
    logic   take_jump;

    assign w = ucode(r_step);

    // Evaluate the jump condition of the current word
    always_comb begin
        unique case (w.jcond)
            JC_NO_INPUT: take_jump = !i_in_valid;
            JC_OUT_BUSY: take_jump = i_out_busy;
            default:     take_jump = 1'b0;
        endcase
    end

    // Pick the next step: jump, wrap or advance
    always_comb begin
        priority if (take_jump) begin
            n_step = w.target;
        end else if (w.last) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Drive datapath strobes
    assign o_in_ready     = w.in_ready;
    assign o_ctl.dsel     = w.dsel;
    assign o_ctl.csel     = w.csel;
    assign o_ctl.acc_op   = w.acc_op;
    assign o_ctl.store_x  = w.store_x;
    assign o_ctl.latch_in = w.in_ready && i_in_valid;
    assign o_ctl.commit   = w.finish && !i_out_busy;

endmodule

### src/bqd_datapath.sv
// Shared multiplier, accumulator, rounding/saturation and delay line.
// Depends on bqd_pkg; driven by bqd_sequencer strobes.
module bqd_datapath #(
    parameter int SAMPLE_BITS    = bqd_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bqd_pkg::t_dp_ctl              i_ctl,
    input  bqd_pkg::t_coefs               i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import bqd_pkg::*;

    localparam int PW    = SAMPLE_BITS + GAIN_W;
    localparam int ACC_W = PW + 3;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_x2;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [SAMPLE_BITS-1:0] r_y2;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [GAIN_W-1:0]      mul_b;
    logic signed [PW-1:0]          prod;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [SAMPLE_BITS-1:0] x_new;

    // Round half up at the fraction point, then clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] s;
        t = v + HALF;
        s = t >>> COEF_FRAC_BITS;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[SAMPLE_BITS-1:0];
    endfunction

    // Select data operand
    always_comb begin
        unique case (i_ctl.dsel)
            DSEL_SAMP: mul_a = r_samp;
            DSEL_X:    mul_a = r_x;
            DSEL_X1:   mul_a = r_x1;
            DSEL_X2:   mul_a = r_x2;
            DSEL_Y1:   mul_a = r_y1;
            DSEL_Y2:   mul_a = r_y2;
            default:   mul_a = r_samp;
        endcase
    end

    // Select coefficient operand, sign-extended to the gain width
    always_comb begin
        unique case (i_ctl.csel)
            CSEL_GAIN: mul_b = i_coefs.input_gain;
            CSEL_B0:   mul_b = {{(GAIN_W-COEF_W){i_coefs.feed_b0[COEF_W-1]}},
                                i_coefs.feed_b0};
            CSEL_B1:   mul_b = {{(GAIN_W-COEF_W){i_coefs.feed_b1[COEF_W-1]}},
                                i_coefs.feed_b1};
            CSEL_B2:   mul_b = {{(GAIN_W-COEF_W){i_coefs.feed_b2[COEF_W-1]}},
                                i_coefs.feed_b2};
            CSEL_A1:   mul_b = {{(GAIN_W-COEF_W){i_coefs.back_a1[COEF_W-1]}},
                                i_coefs.back_a1};
            CSEL_A2:   mul_b = {{(GAIN_W-COEF_W){i_coefs.back_a2[COEF_W-1]}},
                                i_coefs.back_a2};
            default:   mul_b = i_coefs.input_gain;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
    assign x_new    = round_sat(prod_ext);
    assign o_y      = round_sat(r_acc);

    // Multiply, then accumulate the previous product
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        unique case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
        if (i_ctl.latch_in) begin
            r_samp <= i_sample;
        end
    end

    // Hold scaled input and shift the delay line on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else begin
            if (i_ctl.store_x) begin
                r_x <= x_new;
            end
            if (i_ctl.commit) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= o_y;
            end
        end
    end

endmodule
